// File: src/arm_multiply_accumulate_unit_macros.svh
// Assertion macros for the multiply-accumulate unit.
`ifndef ARM_MULTIPLY_ACCUMULATE_UNIT_MACROS_SVH
`define ARM_MULTIPLY_ACCUMULATE_UNIT_MACROS_SVH
`ifndef SYNTHESIS
// Same-cycle implication, sampled on clk, off during reset.
`define AMAC_ASSERT_IMP(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error("assertion failed: same-cycle implication");
// Next-cycle implication, sampled on clk, off during reset.
`define AMAC_ASSERT_NXT(lbl, ante, cons) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error("assertion failed: next-cycle implication");
`else
`define AMAC_ASSERT_IMP(lbl, ante, cons)
`define AMAC_ASSERT_NXT(lbl, ante, cons)
`endif
`endif

// File: src/amac_pkg.sv
// Shared opcode and result types for the multiply-accumulate unit.
`default_nettype none

package amac_pkg;

	typedef enum logic [2:0] {
		ACT_MUL   = 3'd0,
		ACT_MLA   = 3'd1,
		ACT_UNDEF = 3'd2,
		ACT_MLS   = 3'd3,
		ACT_UMULL = 3'd4,
		ACT_UMLAL = 3'd5,
		ACT_SMULL = 3'd6,
		ACT_SMLAL = 3'd7
	} action_t;

	typedef struct packed {
		logic [31:0] result_low;
		logic [31:0] result_high;
		logic        is_long;
		logic        flags_valid;
		logic        flag_negative;
		logic        flag_zero;
		logic        undefined_op;
		logic [31:0] fault_address;
	} amac_result_t;

endpackage

`default_nettype wire

// File: src/amac_finish.sv
// Accumulate, subtract and flag logic applied to the registered product.
`default_nettype none

module amac_finish
	import amac_pkg::*;
(
	input  action_t      action,
	input  logic [63:0]  product,
	input  logic [31:0]  addend_low,
	input  logic [31:0]  addend_high,
	input  logic         set_flags,
	input  logic [31:0]  instr_address,
	output amac_result_t result
);

	logic [63:0] sum;
	logic        long_op;
	logic        flags_on;
	logic        undef;

	// per-opcode arithmetic on the product
	always_comb begin
		sum      = 64'd0;
		long_op  = 1'b0;
		flags_on = 1'b0;
		undef    = 1'b0;
		case (action)
			ACT_MUL: begin
				sum      = product;
				flags_on = set_flags;
			end
			ACT_MLA: begin
				sum      = product + {32'd0, addend_low};
				flags_on = set_flags;
			end
			ACT_MLS: begin
				// never sets flags
				sum = {32'd0, addend_low} - product;
			end
			ACT_UMULL, ACT_SMULL: begin
				sum      = product;
				long_op  = 1'b1;
				flags_on = set_flags;
			end
			ACT_UMLAL, ACT_SMLAL: begin
				sum      = product + {addend_high, addend_low};
				long_op  = 1'b1;
				flags_on = set_flags;
			end
			default: begin
				undef = 1'b1;
			end
		endcase
	end

	// pack the result beat
	always_comb begin
		result.result_low    = sum[31:0];
		result.result_high   = long_op ? sum[63:32] : 32'd0;
		result.is_long       = long_op;
		result.flags_valid   = flags_on;
		result.flag_negative = flags_on & (long_op ? sum[63] : sum[31]);
		result.flag_zero     = flags_on & (long_op ? (sum == 64'd0) : (sum[31:0] == 32'd0));
		result.undefined_op  = undef;
		result.fault_address = undef ? instr_address : 32'd0;
	end

endmodule

`default_nettype wire

// File: src/arm_multiply_accumulate_unit.sv
// Multiply-accumulate execute unit (MUL, MLA, MLS, UMULL, UMLAL, SMULL, SMLAL).
//
// Input channel: in_valid / in_stall carry one instruction beat (opcode, operands,
// set_flags, instruction address). Output channel: out_valid / out_stall carry one
// result beat per input beat, in order.
// Path: an accepted beat passes through the input register, the product register
// and the result register, in that order.
// Throughput: one beat per cycle when not stalled; the 33x33 multiply has its own
// stage, and the 64-bit add plus flag compare sit between product and result registers.
// Stall: when out_stall is high and out_valid is set, the result register holds;
// the earlier stages keep filling, so in_stall rises only once all three stages hold
// a beat. Empty stages are filled even while the output is stalled.
// Reset: arst_n clears all stage valid bits; no result beat is pending afterwards.
// Opcode 2 returns a beat with undefined_op set and fault_address carrying the
// instruction address; all other result fields are zero.
`default_nettype none
`include "arm_multiply_accumulate_unit_macros.svh"

module arm_multiply_accumulate_unit
	import amac_pkg::*;
(
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_stall,
	input  logic [2:0]  action,
	input  logic [31:0] multiplicand,
	input  logic [31:0] multiplier,
	input  logic [31:0] addend_low,
	input  logic [31:0] addend_high,
	input  logic        set_flags,
	input  logic [31:0] instr_address,
	output logic        out_valid,
	input  logic        out_stall,
	output logic [31:0] result_low,
	output logic [31:0] result_high,
	output logic        is_long,
	output logic        flags_valid,
	output logic        flag_negative,
	output logic        flag_zero,
	output logic        undefined_op,
	output logic [31:0] fault_address
);

	// stage valid bits
	logic v_s1;
	logic v_s2;
	logic out_v_q;

	// stage advance enables
	logic adv_out;
	logic adv_s2;
	logic adv_s1;

	// stage 1: operand register
	action_t     action_s1;
	logic [31:0] a_s1;
	logic [31:0] b_s1;
	logic [31:0] lo_s1;
	logic [31:0] hi_s1;
	logic        flags_s1;
	logic [31:0] addr_s1;

	// stage 2: product register
	action_t     action_s2;
	logic [63:0] prod_s2;
	logic [31:0] lo_s2;
	logic [31:0] hi_s2;
	logic        flags_s2;
	logic [31:0] addr_s2;

	// multiply
	logic               sign_mul;
	logic signed [32:0] a_ext;
	logic signed [32:0] b_ext;
	logic signed [65:0] prod_full;

	amac_result_t res_next;
	amac_result_t res_q;

	// handshake: a stage moves when the one after it is empty or moving
	assign adv_out  = !out_v_q || !out_stall;
	assign adv_s2   = !v_s2 || adv_out;
	assign adv_s1   = !v_s1 || adv_s2;
	assign in_stall = !adv_s1;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			v_s1    <= 1'b0;
			v_s2    <= 1'b0;
			out_v_q <= 1'b0;
		end else begin
			if (adv_s1) v_s1 <= in_valid;
			if (adv_s2) v_s2 <= v_s1;
			if (adv_out) out_v_q <= v_s2;
		end
	end

	// operand capture
	always_ff @(posedge clk) begin
		if (adv_s1 && in_valid) begin
			action_s1 <= action_t'(action);
			a_s1      <= multiplicand;
			b_s1      <= multiplier;
			lo_s1     <= addend_low;
			hi_s1     <= addend_high;
			flags_s1  <= set_flags;
			addr_s1   <= instr_address;
		end
	end

	// signed or unsigned 33x33 multiply, low 64 bits kept
	assign sign_mul  = (action_s1 == ACT_SMULL) || (action_s1 == ACT_SMLAL);
	assign a_ext     = $signed({sign_mul & a_s1[31], a_s1});
	assign b_ext     = $signed({sign_mul & b_s1[31], b_s1});
	assign prod_full = a_ext * b_ext;

	always_ff @(posedge clk) begin
		if (adv_s2 && v_s1) begin
			action_s2 <= action_s1;
			prod_s2   <= prod_full[63:0];
			lo_s2     <= lo_s1;
			hi_s2     <= hi_s1;
			flags_s2  <= flags_s1;
			addr_s2   <= addr_s1;
		end
	end

	// accumulate and flags
	amac_finish u_finish (
		.action        (action_s2),
		.product       (prod_s2),
		.addend_low    (lo_s2),
		.addend_high   (hi_s2),
		.set_flags     (flags_s2),
		.instr_address (addr_s2),
		.result        (res_next)
	);

	always_ff @(posedge clk) begin
		if (adv_out && v_s2) begin
			res_q <= res_next;
		end
	end

	// output ports
	assign out_valid     = out_v_q;
	assign result_low    = res_q.result_low;
	assign result_high   = res_q.result_high;
	assign is_long       = res_q.is_long;
	assign flags_valid   = res_q.flags_valid;
	assign flag_negative = res_q.flag_negative;
	assign flag_zero     = res_q.flag_zero;
	assign undefined_op  = res_q.undefined_op;
	assign fault_address = res_q.fault_address;

	// checks
	`AMAC_ASSERT_IMP(a_stall_only_full, in_stall, v_s1 && v_s2 && out_v_q && out_stall)
	`AMAC_ASSERT_NXT(a_s2_reaches_out, v_s2 && adv_out, out_v_q)
	`AMAC_ASSERT_IMP(a_undef_clean, out_v_q && res_q.undefined_op,
		!res_q.is_long && !res_q.flags_valid && (res_q.result_low == 32'd0))
	`AMAC_ASSERT_IMP(a_flags_gate, out_v_q && !res_q.flags_valid,
		!res_q.flag_negative && !res_q.flag_zero)

endmodule

`default_nettype wire

// File: test/arm_multiply_accumulate_unit_test.sv
// Self-checking testbench for the multiply-accumulate unit: directed, random and stall stimulus.
`timescale 1ns / 100ps

module arm_multiply_accumulate_unit_test;
	import amac_pkg::*;

	localparam int RANDOM_BEATS = 1400;
	localparam int IDLE_LIMIT   = 1000;
	localparam int FREEZE_AT    = 500;
	localparam int FREEZE_LEN   = 60;

	// One instruction beat plus its pacing on the input side.
	typedef struct {
		action_t     op;
		logic [31:0] rm;
		logic [31:0] rs;
		logic [31:0] acc_lo;
		logic [31:0] acc_hi;
		logic        want_nz;
		logic [31:0] pc;
		int unsigned lead_gap;
		bit          drain_first;
	} mac_beat_t;

	logic        clk           = 1'b0;
	logic        arst_n        = 1'b0;
	logic        in_valid      = 1'b0;
	logic        in_stall;
	logic [2:0]  action        = 3'd0;
	logic [31:0] multiplicand  = 32'h0;
	logic [31:0] multiplier    = 32'h0;
	logic [31:0] addend_low    = 32'h0;
	logic [31:0] addend_high   = 32'h0;
	logic        set_flags     = 1'b0;
	logic [31:0] instr_address = 32'h0;
	logic        out_valid;
	logic        out_stall     = 1'b0;
	logic [31:0] result_low;
	logic [31:0] result_high;
	logic        is_long;
	logic        flags_valid;
	logic        flag_negative;
	logic        flag_zero;
	logic        undefined_op;
	logic [31:0] fault_address;

	mac_beat_t    pending_beats[$];
	amac_result_t expected_results[$];

	int unsigned beats_total  = 0;
	int unsigned beats_in     = 0;
	int unsigned beats_out    = 0;
	int unsigned idle_cycles  = 0;
	int unsigned fail_count   = 0;
	int unsigned send_wait    = 0;
	int unsigned rx_wait      = 0;
	logic        in_taken     = 1'b0;
	logic        out_taken    = 1'b0;
	logic        rx_frozen    = 1'b0;

	arm_multiply_accumulate_unit u_top (
		.clk           (clk),
		.arst_n        (arst_n),
		.in_valid      (in_valid),
		.in_stall      (in_stall),
		.action        (action),
		.multiplicand  (multiplicand),
		.multiplier    (multiplier),
		.addend_low    (addend_low),
		.addend_high   (addend_high),
		.set_flags     (set_flags),
		.instr_address (instr_address),
		.out_valid     (out_valid),
		.out_stall     (out_stall),
		.result_low    (result_low),
		.result_high   (result_high),
		.is_long       (is_long),
		.flags_valid   (flags_valid),
		.flag_negative (flag_negative),
		.flag_zero     (flag_zero),
		.undefined_op  (undefined_op),
		.fault_address (fault_address)
	);

	always #5 clk = ~clk;

	// Expected result of one multiply beat; products and sums wrap at 32 or 64 bits.
	function automatic amac_result_t predict_mac(input action_t op, input logic [31:0] rm,
			input logic [31:0] rs, input logic [31:0] lo, input logic [31:0] hi,
			input logic want_nz, input logic [31:0] pc);
		amac_result_t r;
		logic [63:0]  acc;
		logic [63:0]  prod_u;
		logic [63:0]  prod_s;
		logic [63:0]  full;
		logic         wide;
		logic         nz;
		r      = '0;
		acc    = {hi, lo};
		prod_u = {32'h0, rm} * {32'h0, rs};
		prod_s = {{32{rm[31]}}, rm} * {{32{rs[31]}}, rs};
		full   = 64'h0;
		wide   = 1'b0;
		nz     = want_nz;
		case (op)
			ACT_MUL: full = {32'h0, prod_u[31:0]};
			ACT_MLA: full = {32'h0, prod_u[31:0] + lo};
			ACT_MLS: begin
				// MLS never touches the flags
				full = {32'h0, lo - prod_u[31:0]};
				nz   = 1'b0;
			end
			ACT_UMULL: begin
				full = prod_u;
				wide = 1'b1;
			end
			ACT_UMLAL: begin
				full = prod_u + acc;
				wide = 1'b1;
			end
			ACT_SMULL: begin
				full = prod_s;
				wide = 1'b1;
			end
			ACT_SMLAL: begin
				full = prod_s + acc;
				wide = 1'b1;
			end
			default: begin
				nz              = 1'b0;
				r.undefined_op  = 1'b1;
				r.fault_address = pc;
			end
		endcase
		r.result_low  = full[31:0];
		r.result_high = wide ? full[63:32] : 32'h0;
		r.is_long     = wide;
		r.flags_valid = nz;
		if (nz) begin
			r.flag_negative = wide ? full[63] : full[31];
			r.flag_zero     = wide ? (full == 64'h0) : (full[31:0] == 32'h0);
		end
		return r;
	endfunction

	task automatic report_mismatch(input string what, input logic [31:0] got,
			input logic [31:0] want);
		$display("%0t: mismatch on %s: got %h, expected %h", $time, what, got, want);
		fail_count++;
	endtask

	task automatic queue_beat(input action_t op, input logic [31:0] rm, input logic [31:0] rs,
			input logic [31:0] lo, input logic [31:0] hi, input logic want_nz,
			input logic [31:0] pc, input int unsigned gap, input bit drain);
		mac_beat_t b;
		b.op          = op;
		b.rm          = rm;
		b.rs          = rs;
		b.acc_lo      = lo;
		b.acc_hi      = hi;
		b.want_nz     = want_nz;
		b.pc          = pc;
		b.lead_gap    = gap;
		b.drain_first = drain;
		pending_beats.push_back(b);
		beats_total++;
	endtask

	// Operand values biased toward the corners of the 32-bit range.
	function automatic logic [31:0] pick_word();
		case ($urandom_range(0, 7))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			2: return 32'h8000_0000;
			3: return 32'h7FFF_FFFF;
			4: return $urandom_range(0, 15);
			default: return $urandom();
		endcase
	endfunction

	// Sender: offers the next beat after its gap; a stalled beat is held as is.
	always @(negedge clk) begin : sender
		mac_beat_t nb;
		if (!arst_n) begin
			in_valid <= 1'b0;
		end else if (!in_valid || in_taken) begin
			if (pending_beats.size() == 0) begin
				in_valid <= 1'b0;
			end else if (send_wait < pending_beats[0].lead_gap ||
					(pending_beats[0].drain_first && expected_results.size() != 0)) begin
				in_valid  <= 1'b0;
				send_wait <= send_wait + 1;
			end else begin
				nb = pending_beats.pop_front();
				action        <= nb.op;
				multiplicand  <= nb.rm;
				multiplier    <= nb.rs;
				addend_low    <= nb.acc_lo;
				addend_high   <= nb.acc_hi;
				set_flags     <= nb.want_nz;
				instr_address <= nb.pc;
				in_valid      <= 1'b1;
				send_wait     <= 0;
			end
		end
	end

	// Receiver: a fresh stall count per result beat, with eager stretches.
	always @(negedge clk) begin : receiver
		int unsigned w;
		logic        hold;
		hold = 1'b0;
		if (out_taken) begin
			w = ((beats_out / 64) % 3 == 0) ? 0 : $urandom_range(0, 6);
			hold    = (w != 0);
			rx_wait <= (w != 0) ? w - 1 : 0;
		end else if (rx_wait != 0) begin
			hold    = 1'b1;
			rx_wait <= rx_wait - 1;
		end
		out_stall <= hold || rx_frozen;
	end

	// Long receiver freeze so the pipe fills and backs up into the input.
	initial begin : rx_long_hold
		while (beats_in < FREEZE_AT)
			@(posedge clk);
		rx_frozen <= 1'b1;
		repeat (FREEZE_LEN) @(posedge clk);
		rx_frozen <= 1'b0;
	end

	// Observer: checks result beats in order, predicts accepted input beats.
	always @(posedge clk) begin : observer
		amac_result_t want;
		in_taken  <= in_valid && !in_stall;
		out_taken <= out_valid && !out_stall;
		if (out_valid && !out_stall) begin
			if (expected_results.size() == 0) begin
				report_mismatch("result beat with nothing outstanding", result_low, 32'h0);
			end else begin
				want = expected_results.pop_front();
				if (result_low !== want.result_low)
					report_mismatch("result_low", result_low, want.result_low);
				if (result_high !== want.result_high)
					report_mismatch("result_high", result_high, want.result_high);
				if (is_long !== want.is_long)
					report_mismatch("is_long", 32'(is_long), 32'(want.is_long));
				if (flags_valid !== want.flags_valid)
					report_mismatch("flags_valid", 32'(flags_valid),
						32'(want.flags_valid));
				if (flag_negative !== want.flag_negative)
					report_mismatch("flag_negative", 32'(flag_negative),
						32'(want.flag_negative));
				if (flag_zero !== want.flag_zero)
					report_mismatch("flag_zero", 32'(flag_zero), 32'(want.flag_zero));
				if (undefined_op !== want.undefined_op)
					report_mismatch("undefined_op", 32'(undefined_op),
						32'(want.undefined_op));
				if (fault_address !== want.fault_address)
					report_mismatch("fault_address", fault_address, want.fault_address);
			end
			beats_out <= beats_out + 1;
		end
		if (in_valid && !in_stall) begin
			expected_results.push_back(predict_mac(action_t'(action), multiplicand,
				multiplier, addend_low, addend_high, set_flags, instr_address));
			beats_in <= beats_in + 1;
		end
		if ((in_valid && !in_stall) || (out_valid && !out_stall))
			idle_cycles <= 0;
		else
			idle_cycles <= idle_cycles + 1;
	end

	// Watchdog on cycles without any accepted beat.
	initial begin : watchdog
		while (idle_cycles < IDLE_LIMIT)
			@(posedge clk);
		$display("Simulation FAILED");
		$finish;
	end

	initial begin : stimulus
		bit burst;
		// directed corners: every opcode, wraparound, zero and negative results
		queue_beat(ACT_MUL,   32'h0,        32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 32'h0, 0, 0);
		queue_beat(ACT_MUL,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 32'h0, 0, 0);
		queue_beat(ACT_MUL,   32'h8000_0000, 32'h1, 32'h0, 32'h0, 1'b1, 32'h4, 0, 0);
		queue_beat(ACT_MLA,   32'hFFFF_FFFF, 32'h1, 32'h1, 32'h0, 1'b1, 32'h8, 0, 0);
		queue_beat(ACT_MLA,   32'h1234_5678, 32'h9ABC_DEF0, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b0, 32'hC, 0, 0);
		queue_beat(ACT_MLA,   32'h4000_0000, 32'h2, 32'h0, 32'h0, 1'b1, 32'h10, 0, 0);
		queue_beat(ACT_UNDEF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b1, 32'hFFFF_FFFF, 0, 0);
		queue_beat(ACT_UNDEF, 32'h0, 32'h0, 32'h0, 32'h0, 1'b0, 32'h0, 0, 0);
		queue_beat(ACT_MLS,   32'h1, 32'h1, 32'h0, 32'h0, 1'b1, 32'h14, 0, 0);
		queue_beat(ACT_MLS,   32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0,
			1'b0, 32'h18, 0, 0);
		queue_beat(ACT_UMULL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'h0, 32'h0, 1'b1, 32'h1C, 0, 0);
		queue_beat(ACT_UMULL, 32'h0, 32'h8000_0000, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b1, 32'h20, 0, 0);
		queue_beat(ACT_UMLAL, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 32'hFFFF_FFFF,
			1'b1, 32'h24, 0, 0);
		queue_beat(ACT_UMLAL, 32'h1, 32'h1, 32'hFFFF_FFFF, 32'hFFFF_FFFF, 1'b1, 32'h28, 0, 0);
		queue_beat(ACT_SMULL, 32'h8000_0000, 32'h8000_0000, 32'h0, 32'h0, 1'b1, 32'h2C, 0, 0);
		queue_beat(ACT_SMULL, 32'hFFFF_FFFF, 32'h1, 32'h0, 32'h0, 1'b1, 32'h30, 0, 0);
		queue_beat(ACT_SMULL, 32'h7FFF_FFFF, 32'h8000_0000, 32'h0, 32'h0, 1'b0, 32'h34, 0, 0);
		queue_beat(ACT_SMLAL, 32'hFFFF_FFFF, 32'h1, 32'h1, 32'h0, 1'b1, 32'h38, 0, 0);
		queue_beat(ACT_SMLAL, 32'h8000_0000, 32'h7FFF_FFFF, 32'h0, 32'h8000_0000,
			1'b1, 32'h3C, 0, 0);
		queue_beat(ACT_SMLAL, 32'h7FFF_FFFF, 32'h7FFF_FFFF, 32'hFFFF_FFFF, 32'h7FFF_FFFF,
			1'b0, 32'h40, 0, 0);

		// random beats: bursts alternate with ragged gaps; the sender drains twice
		for (int i = 0; i < RANDOM_BEATS; i++) begin
			burst = ((i / 100) % 2 == 1) || (i >= 460 && i < 640);
			queue_beat(action_t'($urandom_range(0, 7)), pick_word(), pick_word(),
				pick_word(), pick_word(), 1'($urandom_range(0, 1)), $urandom(),
				burst ? 0 : $urandom_range(0, 6), (i == 0) || (i == 900));
		end

		repeat (4) @(posedge clk);
		@(negedge clk);
		arst_n <= 1'b1;

		while (beats_in != beats_total)
			@(posedge clk);
		while (expected_results.size() != 0)
			@(posedge clk);
		// wait past the pipeline depth to catch stray result beats
		repeat (20) @(posedge clk);

		if (fail_count == 0)
			$display("Simulation PASSED");
		else
			$display("Simulation FAILED");
		$finish;
	end

endmodule

// File: sim.f
+incdir+src
src/amac_pkg.sv
src/amac_finish.sv
src/arm_multiply_accumulate_unit.sv
test/arm_multiply_accumulate_unit_test.sv
